FILE: design/ldp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldp_pkg
// Shared constants and types of the lens distortion projection core.
// ----------------------------------------------------------------------------
package ldp_pkg;

   // Width of every fixed-point intermediate, with 16 fraction bits.
   localparam int CW = 32;
   localparam int FRAC = 16;

   // Scaled dividend width and the number of quotient steps.
   localparam int NUM_W = CW + FRAC;
   localparam int DIV_STEPS = NUM_W;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_FOCAL     = 3'd0,
      REG_PRINCIPAL = 3'd1,
      REG_SKEW      = 3'd2,
      REG_RADIAL12  = 3'd3,
      REG_RADIAL3   = 3'd4,
      REG_TANGENT   = 3'd5
   } ldp_reg_type;

   // One lane pair of the restoring divider plus the point's sideband.
   typedef struct packed {
      logic [NUM_W-1:0] num_x;
      logic [NUM_W-1:0] num_y;
      logic [CW-1:0]    rem_x;
      logic [CW-1:0]    rem_y;
      logic [CW-1:0]    den;
      logic             neg_x;
      logic             neg_y;
      logic             zero;
      logic [31:0]      depth;
   } ldp_div_type;

endpackage

FILE: design/lens_distortion_projection_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lens_distortion_projection_core
// Projects a 3D point through a five-coefficient radial and tangential lens
// distortion model and a camera matrix with skew to a pixel position.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  req     | in        | req_tvalid/tready    | tdata: point_x, point_y, point_z
//  rsp     | out       | rsp_tvalid/tready    | tdata: pixel_x, pixel_y, depth_out;
//          |           |                      | tuser: valid_res
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
//  One point enters per cycle while req_tready is high; each result passes through
//  48 stages of the bit-per-stage divider and 17 arithmetic stages of 32x32
//  multiplies, roundings and saturating sums.
//  Reset clears the valid bits and the configuration registers.
//  A stall on rsp parks one result in a skid register; the pipeline then
//  holds and req_tready drops until the skid register drains.
// ----------------------------------------------------------------------------
module lens_distortion_projection_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // point_x, point_y, point_z
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // pixel_x, pixel_y, depth_out
   output logic [0:0]       rsp_tuser,   // valid_res
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int CW = ldp_pkg::CW;
   localparam int NW = ldp_pkg::NUM_W;
   localparam int NS = 17;
   localparam logic signed [CW-1:0] ONE = CW'(1) <<< ldp_pkg::FRAC;

   typedef struct packed {
      logic signed [CW-1:0]   x, y, x2, y2, xy, r2, r4, r6, tx, ty, c, xd, yd;
      logic signed [CW-1:0]   t0, t1, t2, t3, t4, t5;
      logic signed [2*CW-1:0] m0, m1, m2, m3, m4, m5;
      logic signed [31:0]     px, py;
      logic                   zero;
      logic [31:0]            depth;
   } stage_type;

   // Configuration registers.
   logic [63:0] focal_ff, principal_ff, radial12_ff, tangent_ff;
   logic [31:0] skew_ff, radial3_ff;

   logic                 run;
   logic                 div_in_valid;
   ldp_pkg::ldp_div_type div_in;
   logic                 div_out_valid;
   ldp_pkg::ldp_div_type div_out;
   logic [NS-1:0]        vld_ff;
   stage_type            stg_ff [NS];
   stage_type            stg_in [NS];
   logic                 skid_v_ff;
   logic [96:0]          skid_ff;
   logic [96:0]          tail;

   // Product rounded half away from zero after a right shift, saturated.
   function automatic logic signed [CW-1:0] rnd(input logic signed [2*CW-1:0] p,
                                                input int unsigned s);
      logic              neg;
      logic [2*CW-1:0]   m;
      logic [2*CW-1:0]   r;
      logic [2*CW-1:0]   lim;
      neg = p[2*CW-1];
      m   = neg ? (~p + 1'b1) : p;
      r   = (m + ((2*CW)'(1) << (s - 1))) >> s;
      lim = neg ? ((2*CW)'(1) << (CW - 1)) : (((2*CW)'(1) << (CW - 1)) - 1'b1);
      if (r > lim) begin
         r = lim;
      end
      return neg ? $signed(~r[CW-1:0] + 1'b1) : $signed(r[CW-1:0]);
   endfunction

   // Saturation of a grown sum to the intermediate width.
   function automatic logic signed [CW-1:0] sat(input logic signed [CW+2:0] v);
      logic signed [CW+2:0] hi;
      logic signed [CW+2:0] lo;
      hi = (CW+3)'({1'b0, {(CW-1){1'b1}}});
      lo = -hi - 1'b1;
      if (v > hi) begin
         return hi[CW-1:0];
      end else if (v < lo) begin
         return lo[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

   function automatic logic signed [CW+2:0] ext(input logic signed [CW-1:0] a);
      return (CW+3)'(a);
   endfunction

   function automatic logic signed [2*CW-1:0] mul(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
      logic signed [2*CW-1:0] p;
      p = (2*CW)'(a) * (2*CW)'(b);
      return p;
   endfunction

   // Configuration writes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff     <= '0;
         principal_ff <= '0;
         skew_ff      <= '0;
         radial12_ff  <= '0;
         radial3_ff   <= '0;
         tangent_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            ldp_pkg::REG_FOCAL:     focal_ff     <= csr_data;
            ldp_pkg::REG_PRINCIPAL: principal_ff <= csr_data;
            ldp_pkg::REG_SKEW:      skew_ff      <= csr_data[31:0];
            ldp_pkg::REG_RADIAL12:  radial12_ff  <= csr_data;
            ldp_pkg::REG_RADIAL3:   radial3_ff   <= csr_data[31:0];
            ldp_pkg::REG_TANGENT:   tangent_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves unless a result sits in the skid register.
   assign run        = !skid_v_ff;
   assign req_tready = run;

   // Dividend setup: |X| scaled by 2^16 plus half the divisor for rounding.
   always_comb begin
      logic [31:0] ax, ay, az;
      ax = req_tdata[31] ? (~req_tdata[31:0] + 1'b1) : req_tdata[31:0];
      ay = req_tdata[63] ? (~req_tdata[63:32] + 1'b1) : req_tdata[63:32];
      az = req_tdata[95] ? (~req_tdata[95:64] + 1'b1) : req_tdata[95:64];
      div_in.num_x = {ax, 16'h0} + NW'(az[31:1]);
      div_in.num_y = {ay, 16'h0} + NW'(az[31:1]);
      div_in.rem_x = '0;
      div_in.rem_y = '0;
      div_in.den   = az;
      div_in.neg_x = req_tdata[31] ^ req_tdata[95];
      div_in.neg_y = req_tdata[63] ^ req_tdata[95];
      div_in.zero  = (req_tdata[95:64] == 32'd0);
      div_in.depth = req_tdata[95:64];
   end

   assign div_in_valid = req_tvalid && req_tready;

   ldp_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .run       (run),
      .in_valid  (div_in_valid),
      .in_data   (div_in),
      .out_valid (div_out_valid),
      .out_data  (div_out)
   );

   // Arithmetic stages of multiplies, roundings and sums.
   always_comb begin
      logic [NW-1:0] qx, qy;
      logic [NW-1:0] lx, ly;
      for (int k = 0; k < NS; k++) begin
         stg_in[k] = (k == 0) ? stg_ff[0] : stg_ff[k-1];
      end

      // Quotients saturated and signed.
      lx = div_out.neg_x ? (NW'(1) << (CW - 1)) : ((NW'(1) << (CW - 1)) - 1'b1);
      ly = div_out.neg_y ? (NW'(1) << (CW - 1)) : ((NW'(1) << (CW - 1)) - 1'b1);
      qx = (div_out.num_x > lx) ? lx : div_out.num_x;
      qy = (div_out.num_y > ly) ? ly : div_out.num_y;
      stg_in[0].x     = div_out.neg_x ? $signed(~qx[CW-1:0] + 1'b1) : $signed(qx[CW-1:0]);
      stg_in[0].y     = div_out.neg_y ? $signed(~qy[CW-1:0] + 1'b1) : $signed(qy[CW-1:0]);
      stg_in[0].zero  = div_out.zero;
      stg_in[0].depth = div_out.depth;

      // Squares and cross term.
      stg_in[1].m0 = mul(stg_ff[0].x, stg_ff[0].x);
      stg_in[1].m1 = mul(stg_ff[0].y, stg_ff[0].y);
      stg_in[1].m2 = mul(stg_ff[0].x, stg_ff[0].y);
      stg_in[2].x2 = rnd(stg_ff[1].m0, 16);
      stg_in[2].y2 = rnd(stg_ff[1].m1, 16);
      stg_in[2].xy = rnd(stg_ff[1].m2, 16);
      stg_in[3].r2 = sat(ext(stg_ff[2].x2) + ext(stg_ff[2].y2));

      // Tangential sums and the radial powers.
      stg_in[4].tx = sat(ext(stg_ff[3].r2) + (ext(stg_ff[3].x2) <<< 1));
      stg_in[4].ty = sat(ext(stg_ff[3].r2) + (ext(stg_ff[3].y2) <<< 1));
      stg_in[4].m0 = mul(stg_ff[3].r2, stg_ff[3].r2);
      stg_in[5].r4 = rnd(stg_ff[4].m0, 16);
      stg_in[6].m0 = mul(stg_ff[5].r2, stg_ff[5].r4);
      stg_in[7].r6 = rnd(stg_ff[6].m0, 16);

      // Radial factor.
      stg_in[8].m0 = mul($signed(radial12_ff[31:0]), stg_ff[7].r2);
      stg_in[8].m1 = mul($signed(radial12_ff[63:32]), stg_ff[7].r4);
      stg_in[8].m2 = mul($signed(radial3_ff), stg_ff[7].r6);
      stg_in[9].t0 = rnd(stg_ff[8].m0, 24);
      stg_in[9].t1 = rnd(stg_ff[8].m1, 24);
      stg_in[9].t2 = rnd(stg_ff[8].m2, 24);
      stg_in[10].c = sat(ext(ONE) + ext(stg_ff[9].t0) + ext(stg_ff[9].t1)
                         + ext(stg_ff[9].t2));

      // Distorted coordinates; the doubled cross term uses one shift less.
      stg_in[11].m0 = mul(stg_ff[10].x, stg_ff[10].c);
      stg_in[11].m1 = mul($signed(tangent_ff[31:0]), stg_ff[10].xy);
      stg_in[11].m2 = mul($signed(tangent_ff[63:32]), stg_ff[10].tx);
      stg_in[11].m3 = mul(stg_ff[10].y, stg_ff[10].c);
      stg_in[11].m4 = mul($signed(tangent_ff[31:0]), stg_ff[10].ty);
      stg_in[11].m5 = mul($signed(tangent_ff[63:32]), stg_ff[10].xy);
      stg_in[12].t0 = rnd(stg_ff[11].m0, 16);
      stg_in[12].t1 = rnd(stg_ff[11].m1, 23);
      stg_in[12].t2 = rnd(stg_ff[11].m2, 24);
      stg_in[12].t3 = rnd(stg_ff[11].m3, 16);
      stg_in[12].t4 = rnd(stg_ff[11].m4, 24);
      stg_in[12].t5 = rnd(stg_ff[11].m5, 23);
      stg_in[13].xd = sat(ext(stg_ff[12].t0) + ext(stg_ff[12].t1) + ext(stg_ff[12].t2));
      stg_in[13].yd = sat(ext(stg_ff[12].t3) + ext(stg_ff[12].t4) + ext(stg_ff[12].t5));

      // Camera matrix.
      stg_in[14].m0 = mul($signed(focal_ff[31:0]), stg_ff[13].xd);
      stg_in[14].m1 = mul($signed(skew_ff), stg_ff[13].yd);
      stg_in[14].m2 = mul($signed(focal_ff[63:32]), stg_ff[13].yd);
      stg_in[15].t0 = rnd(stg_ff[14].m0, 16);
      stg_in[15].t1 = rnd(stg_ff[14].m1, 16);
      stg_in[15].t2 = rnd(stg_ff[14].m2, 16);
      stg_in[16].px = stg_ff[15].zero ? '0 :
                      sat(ext(stg_ff[15].t0) + ext(stg_ff[15].t1)
                          + ext($signed(principal_ff[31:0])));
      stg_in[16].py = stg_ff[15].zero ? '0 :
                      sat(ext(stg_ff[15].t2) + ext($signed(principal_ff[63:32])));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (run) begin
         vld_ff <= {vld_ff[NS-2:0], div_out_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         for (int k = 0; k < NS; k++) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   // Skid register catches the tail result when the consumer stalls.
   assign tail = {!stg_ff[NS-1].zero, stg_ff[NS-1].depth,
                  stg_ff[NS-1].py, stg_ff[NS-1].px};

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_tready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (vld_ff[NS-1] && !rsp_tready) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         skid_ff <= tail;
      end
   end

   assign rsp_tvalid = skid_v_ff || vld_ff[NS-1];
   assign rsp_tdata  = skid_v_ff ? skid_ff[95:0] : tail[95:0];
   assign rsp_tuser  = skid_v_ff ? skid_ff[96:96] : tail[96:96];

endmodule
`default_nettype wire

FILE: design/ldp_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldp_divider
// Pipelined restoring divider, one quotient bit per stage, for the X and Y
// lanes that share the depth as divisor.
// ----------------------------------------------------------------------------
module ldp_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 run,
   input  wire logic                 in_valid,
   input  wire ldp_pkg::ldp_div_type in_data,
   output logic                      out_valid,
   output ldp_pkg::ldp_div_type      out_data
);

   localparam int N = ldp_pkg::DIV_STEPS;
   localparam int CW = ldp_pkg::CW;
   localparam int NW = ldp_pkg::NUM_W;

   logic [N-1:0]         vld_ff;
   ldp_pkg::ldp_div_type stg_ff [N];
   ldp_pkg::ldp_div_type stg_in [N];

   // One restoring step on both lanes: shift in the next dividend bit and
   // subtract the divisor when it fits.
   function automatic ldp_pkg::ldp_div_type step(input ldp_pkg::ldp_div_type d);
      ldp_pkg::ldp_div_type o;
      logic [CW:0] sx;
      logic [CW:0] sy;
      logic        gx;
      logic        gy;
      o  = d;
      sx = {d.rem_x, d.num_x[NW-1]};
      sy = {d.rem_y, d.num_y[NW-1]};
      gx = (sx >= {1'b0, d.den});
      gy = (sy >= {1'b0, d.den});
      o.rem_x = gx ? CW'(sx - {1'b0, d.den}) : sx[CW-1:0];
      o.rem_y = gy ? CW'(sy - {1'b0, d.den}) : sy[CW-1:0];
      o.num_x = {d.num_x[NW-2:0], gx};
      o.num_y = {d.num_y[NW-2:0], gy};
      return o;
   endfunction

   // Step logic of every stage.
   always_comb begin
      stg_in[0] = step(in_data);
      for (int k = 1; k < N; k++) begin
         stg_in[k] = step(stg_ff[k-1]);
      end
   end

   // Valid bits travel with the data and freeze on a stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (run) begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         for (int k = 0; k < N; k++) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_data  = stg_ff[N-1];

endmodule
`default_nettype wire

FILE: design/ldp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldp_checker
// Port-level assertions for the lens distortion projection core.
// ----------------------------------------------------------------------------
module ldp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [95:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   // A stalled result transfer keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // With no result pending, the input side is never stalled.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // A zero-depth result carries zero pixels; a projected one nonzero depth.
   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[63:0] == 64'd0 &&
                                      rsp_tdata[95:64] == 32'd0)
      else $error("zero-depth result has pixel data");

   a_valid_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[95:64] != 32'd0)
      else $error("projected result with zero depth");

endmodule

bind lens_distortion_projection_core ldp_checker u_ldp_checker (.*);
`default_nettype wire

FILE: tb/lens_distortion_projection_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_distortion_projection_core_tb
// Streams 3D points through the projection core and checks every pixel
// result against a fixed-point predictor of the distortion model and camera
// matrix, across several register settings, with random bursts and stalls.
// ----------------------------------------------------------------------------
module lens_distortion_projection_core_tb;

   // Expected result of one point.
   typedef struct {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] depth;
      logic        ok;
   } pixel_type;

   localparam int LATENCY = 65;
   localparam longint CYCLE_LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [63:0]  csr_data = '0;

   // Predictor copy of the registers.
   logic [63:0]  focal_reg, principal_reg, radial12_reg, tangent_reg;
   logic [31:0]  skew_reg, radial3_reg;

   logic [95:0]  point_queue[$];
   pixel_type    pixel_queue[$];
   int           mismatches = 0;
   longint       cycles = 0;
   bit           hold_off = 0;
   bit           req_done = 0;
   int           burst_left = 0;
   int           gap_left = 0;

   lens_distortion_projection_core i_dut (.*);

   // Clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint sat_signed(longint v, int w);
      longint hi;
      hi = (64'sd1 <<< (w - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
   endfunction

   // Product scaled down by 2^s, rounded half away from zero, saturated.
   function automatic longint round_mul(longint a, longint b, int s);
      logic signed [127:0] p;
      logic [127:0] m;
      p = 128'(signed'(a)) * 128'(signed'(b));
      m = p < 0 ? -p : p;
      m = (m + (128'd1 << (s - 1))) >> s;
      if (m > 128'h7FFFFFFF + (p < 0 ? 1 : 0)) m = 128'h7FFFFFFF + (p < 0 ? 1 : 0);
      return p < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint round_div(longint n, longint d);
      logic [127:0] num, den, q;
      bit neg;
      neg = (n < 0) != (d < 0);
      num = (n < 0 ? -n : n) << 16;
      den = d < 0 ? -d : d;
      q = (num + den / 2) / den;
      if (q > 128'h7FFFFFFF + neg) q = 128'h7FFFFFFF + neg;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint sx(logic [31:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic pixel_type project_point(logic [95:0] pt);
      pixel_type r;
      longint x, y, z, x2, y2, xy, r2, r4, r6, c, xd, yd;
      z = sx(pt[95:64]);
      r.depth = pt[95:64];
      r.px = '0;
      r.py = '0;
      r.ok = 1'b0;
      if (z == 0) return r;
      x = round_div(sx(pt[31:0]), z);
      y = round_div(sx(pt[63:32]), z);
      x2 = round_mul(x, x, 16);
      y2 = round_mul(y, y, 16);
      xy = round_mul(x, y, 16);
      r2 = sat_signed(x2 + y2, 32);
      r4 = round_mul(r2, r2, 16);
      r6 = round_mul(r2, r4, 16);
      c = sat_signed(65536 + round_mul(sx(radial12_reg[31:0]), r2, 24)
            + round_mul(sx(radial12_reg[63:32]), r4, 24)
            + round_mul(sx(radial3_reg), r6, 24), 32);
      xd = sat_signed(round_mul(x, c, 16) + round_mul(sx(tangent_reg[31:0]), xy, 23)
            + round_mul(sx(tangent_reg[63:32]), sat_signed(r2 + 2 * x2, 32), 24), 32);
      yd = sat_signed(round_mul(y, c, 16)
            + round_mul(sx(tangent_reg[31:0]), sat_signed(r2 + 2 * y2, 32), 24)
            + round_mul(sx(tangent_reg[63:32]), xy, 23), 32);
      r.px = 32'(sat_signed(round_mul(sx(focal_reg[31:0]), xd, 16)
            + round_mul(sx(skew_reg), yd, 16) + sx(principal_reg[31:0]), 32));
      r.py = 32'(sat_signed(round_mul(sx(focal_reg[63:32]), yd, 16)
            + sx(principal_reg[63:32]), 32));
      r.ok = 1'b1;
      return r;
   endfunction

   // Point driver: bursts of random length separated by random gaps.
   // An offered point stays on the bus until its transfer has been seen.
   always @(negedge clock) begin
      if (!reset) begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
         if (req_tvalid && !req_done) begin
            req_tvalid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (point_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= point_queue[0];
            if (burst_left > 0) burst_left--;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: own stall pattern, plus a long hold-off when asked.
   always @(negedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else if (cycles % 200 < 60) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // Input transfer tracking and result monitor.
   always @(posedge clock) begin
      pixel_type e;
      cycles++;
      req_done = !reset && req_tvalid && req_tready;
      if (req_done) begin
         pixel_queue.push_back(project_point(req_tdata));
         void'(point_queue.pop_front());
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result transfer %h", rsp_tdata);
         end else begin
            e = pixel_queue.pop_front();
            if (rsp_tdata[31:0] !== e.px || rsp_tdata[63:32] !== e.py
                || rsp_tdata[95:64] !== e.depth || rsp_tuser[0] !== e.ok) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %h %h %h %b, got %h %h %h %b",
                     e.px, e.py, e.depth, e.ok, rsp_tdata[31:0], rsp_tdata[63:32],
                     rsp_tdata[95:64], rsp_tuser[0]);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL lens_distortion_projection_core");
         $finish;
      end
   end

   task automatic write_reg(ldp_pkg::ldp_reg_type idx, logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         ldp_pkg::REG_FOCAL:     focal_reg = value;
         ldp_pkg::REG_PRINCIPAL: principal_reg = value;
         ldp_pkg::REG_SKEW:      skew_reg = value[31:0];
         ldp_pkg::REG_RADIAL12:  radial12_reg = value;
         ldp_pkg::REG_RADIAL3:   radial3_reg = value[31:0];
         ldp_pkg::REG_TANGENT:   tangent_reg = value;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (point_queue.size() > 0 || req_tvalid || pixel_queue.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // Random coordinate: mostly modest values, sometimes any 32-bit pattern.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 32'h000A0000)) - 32'sh00050000);
         default: return 32'($signed($urandom_range(0, 32'h00400000)) - 32'sh00200000);
      endcase
   endfunction

   function automatic logic [31:0] rand_depth();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'd0;
         default: return 32'($urandom_range(32'h00004000, 32'h00400000))
            * ($urandom_range(0, 1) ? 1 : -1);
      endcase
   endfunction

   // Random coefficient in Q8.24: small distortion usually, wide now and then.
   function automatic logic [31:0] rand_coef();
      if ($urandom_range(0, 4) == 0) return $urandom();
      return 32'($signed($urandom_range(0, 32'h00400000)) - 32'sh00200000);
   endfunction

   task automatic random_setting();
      write_reg(ldp_pkg::REG_FOCAL, {32'($urandom_range(32'h00010000, 32'h04000000)),
                                     32'($urandom_range(32'h00010000, 32'h04000000))});
      write_reg(ldp_pkg::REG_PRINCIPAL, {32'($urandom_range(0, 32'h04000000)),
                                         32'($urandom_range(0, 32'h04000000))});
      write_reg(ldp_pkg::REG_SKEW,
                {32'd0, 32'($signed($urandom_range(0, 32'h20000)) - 32'sh10000)});
      write_reg(ldp_pkg::REG_RADIAL12, {rand_coef(), rand_coef()});
      write_reg(ldp_pkg::REG_RADIAL3, {32'd0, rand_coef()});
      write_reg(ldp_pkg::REG_TANGENT, {rand_coef(), rand_coef()});
   endtask

   initial begin
      focal_reg = '0;
      principal_reg = '0;
      radial12_reg = '0;
      tangent_reg = '0;
      skew_reg = '0;
      radial3_reg = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed points with the registers at reset.
      point_queue.push_back({32'd0, 32'h7FFFFFFF, 32'h80000000});
      point_queue.push_back({32'h00010000, 32'h00010000, 32'h00010000});
      wait_drained();

      // Extreme coefficients and camera matrix, then directed corner points.
      write_reg(ldp_pkg::REG_FOCAL, 64'h7FFFFFFF_80000000);
      write_reg(ldp_pkg::REG_PRINCIPAL, 64'h80000000_7FFFFFFF);
      write_reg(ldp_pkg::REG_SKEW, 64'hFFFFFFFF_80000000);
      write_reg(ldp_pkg::REG_RADIAL12, 64'h7FFFFFFF_80000000);
      write_reg(ldp_pkg::REG_RADIAL3, 64'h00000000_7FFFFFFF);
      write_reg(ldp_pkg::REG_TANGENT, 64'h80000000_7FFFFFFF);
      point_queue.push_back({32'h00000001, 32'h7FFFFFFF, 32'h80000000});
      point_queue.push_back({32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF});
      point_queue.push_back({32'h00000000, 32'h00000000, 32'h00000000});
      point_queue.push_back({32'h80000000, 32'h80000000, 32'h80000000});
      point_queue.push_back({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
      point_queue.push_back({32'h00000001, 32'h00008000, 32'hFFFF8000});
      wait_drained();

      // Moderate lens, directed points including a zero depth.
      write_reg(ldp_pkg::REG_FOCAL, {32'h01F40000, 32'h01F40000});
      write_reg(ldp_pkg::REG_PRINCIPAL, {32'h00F00000, 32'h01400000});
      write_reg(ldp_pkg::REG_SKEW, 64'h0000_0000_0000_0100);
      write_reg(ldp_pkg::REG_RADIAL12, {32'h00080000, 32'hFFC00000});
      write_reg(ldp_pkg::REG_RADIAL3, 64'h0000_0000_0000_1000);
      write_reg(ldp_pkg::REG_TANGENT, {32'hFFFF0000, 32'h00010000});
      point_queue.push_back({32'h00020000, 32'h00008000, 32'h00010000});
      point_queue.push_back({32'h00020000, 32'hFFFF8000, 32'h00010000});
      point_queue.push_back({32'hFFFE0000, 32'h00000000, 32'h12345678});
      point_queue.push_back({32'h00000000, 32'h7FFFFFFF, 32'h80000000});
      wait_drained();

      // Random phases, each with its own register setting; one long hold-off.
      for (int ph = 0; ph < 6; ph++) begin
         random_setting();
         for (int i = 0; i < 325; i++)
            point_queue.push_back({rand_depth(), rand_coord(), rand_coord()});
         if (ph == 2) begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         wait_drained();
      end

      if (mismatches == 0) $display("PASS lens_distortion_projection_core");
      else $display("FAIL lens_distortion_projection_core");
      $finish;
   end

endmodule
